// ===== rtl/core/ieh_pkg.sv =====
// ----------------------------------------------------------------------------
// ieh_pkg
// Shared types and constants for the IPv4 over Ethernet header builder.
// ----------------------------------------------------------------------------
package ieh_pkg;

    localparam int HDR_LEN   = 34;
    localparam int CNT_W     = $clog2(HDR_LEN);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_UP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MTU       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_LINK_DOWN = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

    localparam logic [15:0] MTU_RESET     = 16'd1500;
    localparam logic [7:0]  IP_VER_IHL    = 8'h45;
    localparam logic [15:0] IP_FLAGS_DF   = 16'h4000;
    localparam logic [7:0]  IP_TTL        = 8'd64;
    localparam logic [15:0] ETHERTYPE_IP  = 16'h0800;
    localparam logic [16:0] IP_HDR_BYTES  = 17'd20;
    localparam logic [3:0]  CLASS_D_NIB   = 4'hE;
    localparam logic [23:0] MCAST_OUI     = 24'h01005E;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  ip_protocol;
        logic [15:0] payload_bytes;
    } t_req;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       last_byte;
        logic [1:0] status;
    } t_res;

endpackage

// ===== rtl/core/ipv4_ethernet_header_builder.sv =====
// ----------------------------------------------------------------------------
// ipv4_ethernet_header_builder
// Builds the 34-byte Ethernet II + IPv4 header for each send request and
// streams it out one byte per result, or a single error result.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  request   in         i_req_valid / o_req_ready    i_req (t_req)
//  result    out        o_res_valid / i_res_ready    o_res (t_res)
//  config    in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
//  A request is registered on accept along with the partial address sum, then
//  the header and checksum are formed from it and loaded into the frame register.
//  The frame register emits 34 results, one a cycle while i_res_ready is high,
//  or one error result; the result channel sets the sustained request rate.
//  A second request is held in the input register while a frame drains.
//  Synchronous active-low reset empties both stages and restores config.
// ----------------------------------------------------------------------------
module ipv4_ethernet_header_builder (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_req_valid,
    output logic                                    o_req_ready,
    input  ieh_pkg::t_req                           i_req,
    output logic                                    o_res_valid,
    input  logic                                    i_res_ready,
    output ieh_pkg::t_res                           o_res,
    input  logic                                    i_cfg_we,
    input  logic [ieh_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [ieh_pkg::CFG_DAT_W-1:0]           i_cfg_data
);
    import ieh_pkg::*;

    // Configuration
    logic        r_link_up;
    logic [15:0] r_mtu;
    logic [47:0] r_local_mac;

    // Input stage
    logic        r_ivalid;
    t_req        r_req;
    logic [17:0] r_addr_sum;

    // Frame stage
    logic                          r_fvalid;
    logic [HDR_LEN-1:0][7:0]       r_hdr;
    logic [1:0]                    r_status;
    logic [CNT_W-1:0]              r_cnt;

    logic                          n_ivalid;
    logic [17:0]                   n_addr_sum;
    logic [HDR_LEN-1:0][7:0]       n_hdr;
    logic [1:0]                    n_status;
    logic [16:0]                   total;
    logic [19:0]                   sum;
    logic [16:0]                   fold1;
    logic [15:0]                   fold2;
    logic [15:0]                   cksum;
    logic                          is_err;
    logic                          is_last;
    logic                          out_fire;
    logic                          frame_free;
    logic                          load;
    logic                          req_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_up   <= 1'b0;
            r_mtu       <= MTU_RESET;
            r_local_mac <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINK_UP:   r_link_up   <= i_cfg_data[0];
                CFG_MTU:       r_mtu       <= i_cfg_data[15:0];
                CFG_LOCAL_MAC: r_local_mac <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake
    assign is_err     = (r_status != STATUS_OK);
    assign is_last    = is_err || (r_cnt == CNT_W'(HDR_LEN - 1));
    assign out_fire   = r_fvalid && i_res_ready;
    assign frame_free = !r_fvalid || (out_fire && is_last);
    assign load       = r_ivalid && frame_free;
    assign o_req_ready = !r_ivalid || load;
    assign req_fire   = i_req_valid && o_req_ready;
    assign n_ivalid   = req_fire || (r_ivalid && !load);

    // Address words of the checksum, summed on accept
    assign n_addr_sum = 18'(i_req.src_ip[31:16]) + 18'(i_req.src_ip[15:0])
                      + 18'(i_req.dst_ip[31:16]) + 18'(i_req.dst_ip[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ivalid <= 1'b0;
        end else begin
            r_ivalid <= n_ivalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req      <= i_req;
            r_addr_sum <= n_addr_sum;
        end
    end

    // Header and checksum
    always_comb begin
        total = IP_HDR_BYTES + 17'(r_req.payload_bytes);
        sum   = 20'(r_addr_sum) + 20'(total[15:0]) + 20'({IP_TTL, r_req.ip_protocol})
              + 20'({IP_VER_IHL, 8'h00}) + 20'(IP_FLAGS_DF);
        fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
        fold2 = fold1[15:0] + 16'(fold1[16]);
        cksum = ~fold2;

        if (!r_link_up) begin
            n_status = STATUS_LINK_DOWN;
        end else if (total > 17'(r_mtu)) begin
            n_status = STATUS_TOO_LONG;
        end else begin
            n_status = STATUS_OK;
        end

        if (r_req.dst_ip[31:28] == CLASS_D_NIB) begin
            n_hdr[0] = MCAST_OUI[23:16];
            n_hdr[1] = MCAST_OUI[15:8];
            n_hdr[2] = MCAST_OUI[7:0];
            n_hdr[3] = {1'b0, r_req.dst_ip[22:16]};
            n_hdr[4] = r_req.dst_ip[15:8];
            n_hdr[5] = r_req.dst_ip[7:0];
        end else begin
            for (int i = 0; i < 6; i++) begin
                n_hdr[i] = 8'hFF;
            end
        end
        for (int i = 0; i < 6; i++) begin
            n_hdr[6 + i] = r_local_mac[8*(5-i) +: 8];
        end
        n_hdr[12] = ETHERTYPE_IP[15:8];
        n_hdr[13] = ETHERTYPE_IP[7:0];
        n_hdr[14] = IP_VER_IHL;
        n_hdr[15] = 8'h00;
        n_hdr[16] = total[15:8];
        n_hdr[17] = total[7:0];
        n_hdr[18] = 8'h00;
        n_hdr[19] = 8'h00;
        n_hdr[20] = IP_FLAGS_DF[15:8];
        n_hdr[21] = IP_FLAGS_DF[7:0];
        n_hdr[22] = IP_TTL;
        n_hdr[23] = r_req.ip_protocol;
        n_hdr[24] = cksum[15:8];
        n_hdr[25] = cksum[7:0];
        for (int i = 0; i < 4; i++) begin
            n_hdr[26 + i] = r_req.src_ip[8*(3-i) +: 8];
            n_hdr[30 + i] = r_req.dst_ip[8*(3-i) +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= 1'b0;
            r_cnt    <= '0;
        end else if (load) begin
            r_fvalid <= 1'b1;
            r_cnt    <= '0;
        end else if (out_fire) begin
            // drop the frame after its last result, else advance
            if (is_last) begin
                r_fvalid <= 1'b0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_hdr    <= n_hdr;
            r_status <= n_status;
        end
    end

    assign o_res_valid       = r_fvalid;
    assign o_res.header_byte = is_err ? 8'h00 : r_hdr[r_cnt];
    assign o_res.last_byte   = is_last;
    assign o_res.status      = r_status;

endmodule

// ===== tb/tb_ipv4_ethernet_header_builder.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_ethernet_header_builder
// Self-checking bench for the Ethernet II + IPv4 header builder. Send requests
// go in through a valid/ready channel with random gaps. Each one is predicted
// into its 34 header bytes, with the checksum and the multicast MAC mapping,
// or into a single link-down or over-MTU error. Results drain under random
// back-pressure and are compared in order. Several register settings are
// covered, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ipv4_ethernet_header_builder;

    import ieh_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LATENCY_PAD    = 8;
    localparam int MAX_WAIT       = 11;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_ITEMS    = 40;
    localparam int NUM_PHASES     = 8;

    // unused register slot; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    class header_scoreboard;
        logic        link_up;
        logic [15:0] mtu;
        logic [47:0] local_mac;
        t_res        pending_bytes[$];
        int          mismatches;

        function new();
            link_up    = 1'b0;
            mtu        = MTU_RESET;
            local_mac  = '0;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_LINK_UP:   link_up = data[0];
                CFG_MTU:       mtu = data[15:0];
                CFG_LOCAL_MAC: local_mac = data[47:0];
                default: ;
            endcase
        endfunction

        function void push_error(logic [1:0] code);
            t_res r;
            r.header_byte = 8'h00;
            r.last_byte   = 1'b1;
            r.status      = code;
            pending_bytes.push_back(r);
        endfunction

        // Build the expected wire bytes for one accepted request.
        function void predict_header(t_req req);
            logic [16:0] total;
            logic [7:0]  hdr [HDR_LEN];
            logic [31:0] acc;
            logic [15:0] csum;
            t_res        r;
            total = IP_HDR_BYTES + {1'b0, req.payload_bytes};
            if (!link_up) begin
                push_error(STATUS_LINK_DOWN);
                return;
            end
            if (total > {1'b0, mtu}) begin
                push_error(STATUS_TOO_LONG);
                return;
            end
            if (req.dst_ip[31:28] == CLASS_D_NIB) begin
                hdr[0] = MCAST_OUI[23:16];
                hdr[1] = MCAST_OUI[15:8];
                hdr[2] = MCAST_OUI[7:0];
                hdr[3] = {1'b0, req.dst_ip[22:16]};
                hdr[4] = req.dst_ip[15:8];
                hdr[5] = req.dst_ip[7:0];
            end else begin
                for (int i = 0; i < 6; i++) hdr[i] = 8'hFF;
            end
            for (int i = 0; i < 6; i++) hdr[6 + i] = local_mac[47 - 8 * i -: 8];
            hdr[12] = ETHERTYPE_IP[15:8];
            hdr[13] = ETHERTYPE_IP[7:0];
            hdr[14] = IP_VER_IHL;
            hdr[15] = 8'h00;
            hdr[16] = total[15:8];
            hdr[17] = total[7:0];
            hdr[18] = 8'h00;
            hdr[19] = 8'h00;
            hdr[20] = IP_FLAGS_DF[15:8];
            hdr[21] = IP_FLAGS_DF[7:0];
            hdr[22] = IP_TTL;
            hdr[23] = req.ip_protocol;
            hdr[24] = 8'h00;
            hdr[25] = 8'h00;
            for (int i = 0; i < 4; i++) begin
                hdr[26 + i] = req.src_ip[31 - 8 * i -: 8];
                hdr[30 + i] = req.dst_ip[31 - 8 * i -: 8];
            end
            // one's-complement sum over the ten IPv4 header words
            acc = '0;
            for (int i = 14; i < HDR_LEN; i += 2) acc += {16'h0, hdr[i], hdr[i + 1]};
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
            csum = ~acc[15:0];
            hdr[24] = csum[15:8];
            hdr[25] = csum[7:0];
            for (int i = 0; i < HDR_LEN; i++) begin
                r.header_byte = hdr[i];
                r.last_byte   = (i == HDR_LEN - 1);
                r.status      = STATUS_OK;
                pending_bytes.push_back(r);
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result byte %02h last %0b status %0d",
                             $time, got.header_byte, got.last_byte, got.status);
                return;
            end
            want = pending_bytes.pop_front();
            if (got.header_byte !== want.header_byte || got.last_byte !== want.last_byte ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: expected %02h/%0b/%0d got %02h/%0b/%0d (byte/last/status)",
                             $time, want.header_byte, want.last_byte, want.status,
                             got.header_byte, got.last_byte, got.status);
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_req_valid = 1'b0;
    logic                  o_req_ready;
    t_req                  i_req       = '0;
    logic                  o_res_valid;
    logic                  i_res_ready = 1'b0;
    t_res                  o_res;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data  = '0;

    header_scoreboard sb;
    bit               idle_on = 1'b1;
    int               quiet_cycles = 0;

    ipv4_ethernet_header_builder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Monitor both channels and guard against a hung block.
    always @(posedge i_clk) begin
        if (i_rst_n && i_req_valid && o_req_ready) sb.predict_header(i_req);
        if (i_rst_n && o_res_valid && i_res_ready) sb.check_result(o_res);
        if ((i_req_valid && o_req_ready) || (o_res_valid && i_res_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("ipv4_ethernet_header_builder test failed");
                $finish;
            end
        end
    end

    // Result sink: draw a stall before taking each result.
    initial begin : result_sink
        int stall;
        @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                i_res_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_res_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_res_valid) @(posedge i_clk);
        end
    end

    // Valid is only lowered when a gap follows, so it never toggles in one step.
    task automatic send_request(input t_req req);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= req;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
    endtask

    // Hold off until every expected result is out, then let the pipe settle.
    // Wait for the clock first so the monitor has noted the last accepted request.
    task automatic drain();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.set_register(idx, data);
        @(posedge i_clk);
    endtask

    // Upper data bits carry junk to check that each register keeps only its width.
    task automatic configure(input logic link, input logic [15:0] mtu_val,
                             input logic [47:0] mac);
        logic [47:0] junk;
        junk = {16'($urandom), $urandom};
        put_reg(CFG_LINK_UP, {junk[47:1], link});
        put_reg(CFG_MTU, {junk[47:16], mtu_val});
        put_reg(CFG_LOCAL_MAC, mac);
        put_reg(CFG_SPARE, junk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_req random_request(input logic [15:0] mtu_val);
        t_req req;
        int   limit;
        int   pick;
        int   len;
        req.src_ip      = $urandom;
        req.dst_ip      = $urandom;
        req.ip_protocol = 8'($urandom);
        if ($urandom_range(0, 9) < 4) req.dst_ip[31:28] = CLASS_D_NIB;
        limit = int'(mtu_val) - int'(IP_HDR_BYTES);
        pick  = $urandom_range(0, 9);
        if (pick < 6 && limit >= 0) begin
            len = $urandom_range(0, limit);
        end else if (pick < 8) begin
            // straddle the MTU boundary
            len = limit + $urandom_range(0, 2) - 1;
            if (len < 0) len = 0;
            if (len > 65535) len = 65535;
        end else begin
            len = $urandom_range(0, 65535);
        end
        req.payload_bytes = 16'(len);
        return req;
    endfunction

    initial begin
        logic [15:0] mtu_pick [NUM_PHASES];
        logic [15:0] mtu_val;
        logic [47:0] mac;
        logic        link;
        int          count;
        sb = new();
        mtu_pick = '{16'd1500, 16'd65535, 16'd21, 16'd0, 16'd576, 16'd65535, 16'd0, 16'd9000};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // link is down out of reset, which wins even over an oversized request
        send_request(t_req'{32'hC0A80001, 32'hE0000001, 8'd17, 16'd100});
        send_request(t_req'{32'hFFFFFFFF, 32'h0A000001, 8'd6, 16'hFFFF});
        drain();

        configure(1'b1, MTU_RESET, 48'h0);
        send_request(t_req'{32'h0A000001, 32'h0A000002, 8'd17, 16'd1480});
        send_request(t_req'{32'h0A000001, 32'h0A000002, 8'd17, 16'd1481});
        send_request(t_req'{32'h00000000, 32'hE0FFFFFF, 8'd0, 16'd0});
        send_request(t_req'{32'hFFFFFFFF, 32'hEFFFFFFF, 8'd255, 16'd8});
        send_request(t_req'{32'h12345678, 32'hDFFFFFFF, 8'd1, 16'd64});
        send_request(t_req'{32'h80000001, 32'hF0000000, 8'd2, 16'd1});
        drain();

        configure(1'b1, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_request(t_req'{32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255, 16'd65515});
        send_request(t_req'{32'hFFFFFFFF, 32'hEFFFFFFF, 8'd255, 16'd65516});
        send_request(t_req'{32'h01020304, 32'hE1020304, 8'd89, 16'hFFFF});
        send_request(t_req'{32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255, 16'd0});
        send_request(t_req'{32'h7FFFFFFF, 32'h00000000, 8'd128, 16'h8000});
        drain();

        configure(1'b1, 16'd0, 48'h0123_4567_89AB);
        send_request(t_req'{32'h0A0A0A0A, 32'hE0000001, 8'd17, 16'd0});
        drain();

        configure(1'b1, IP_HDR_BYTES[15:0], 48'hA5A5_5A5A_F00F);
        send_request(t_req'{32'h0A0A0A0A, 32'hE7654321, 8'd17, 16'd0});
        send_request(t_req'{32'h0A0A0A0A, 32'hE7654321, 8'd17, 16'd1});
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            link    = (ph != 3);
            mtu_val = (mtu_pick[ph] == 16'd0) ? 16'($urandom) : mtu_pick[ph];
            mac     = (ph == 1) ? 48'hFFFF_FFFF_FFFF : (ph == 4) ? 48'h0 :
                      {16'($urandom), $urandom};
            idle_on = !(ph == 2 || ph == 5);
            configure(link, mtu_val, mac);
            count = link ? PHASE_ITEMS : PHASE_ITEMS / 4;
            for (int n = 0; n < count; n++) send_request(random_request(mtu_val));
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
            $display("ipv4_ethernet_header_builder test passed");
        end else begin
            $display("ipv4_ethernet_header_builder test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ieh_pkg.sv
rtl/core/ipv4_ethernet_header_builder.sv
tb/tb_ipv4_ethernet_header_builder.sv
